### sv/decimal_line_range_parser_assert.svh
// ----------------------------------------------------------------------------
// Decimal line range parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LINE_RANGE_PARSER_ASSERT_SVH
`define DECIMAL_LINE_RANGE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLRP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal line range parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define DLRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal line range parser check failed");

`endif

### sv/dlrp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal line range parser package
// Widths, character codes, status codes and register indexes of the parser.
// ----------------------------------------------------------------------------
package dlrp_pkg;

    localparam int BYTE_W             = 8;
    localparam int NUM_W              = 16;
    localparam int STATUS_W           = 3;
    localparam int MAG_W              = 32;
    localparam int CFG_INDEX_W        = 1;
    localparam int LINE_LIMIT_DEFAULT = 64;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_VTAB    = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FEED    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_RETURN  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic [MAG_W-1:0] MAG_CAP = 32'h8000_0000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ALLOWED = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ALLOWED = 1'd1;

    localparam logic signed [NUM_W-1:0] MIN_ALLOWED_RESET = 16'sh8000;
    localparam logic signed [NUM_W-1:0] MAX_ALLOWED_RESET = 16'sh7FFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED,
        ST_NOT_NUMBER,
        ST_TOO_SMALL,
        ST_TOO_LARGE,
        ST_TOO_LONG
    } status_t;

endpackage

### sv/dlrp_if.sv
// ----------------------------------------------------------------------------
// Decimal line range parser channels
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface dlrp_byte_if;

    logic                          valid;
    logic                          ready;
    logic [dlrp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

interface dlrp_result_if;

    logic                                 valid;
    logic                                 ready;
    logic [dlrp_pkg::STATUS_W-1:0]        status;
    logic signed [dlrp_pkg::NUM_W-1:0]    number;

    modport source (output valid, output status, output number, input ready);
    modport sink (input valid, input status, input number, output ready);

endinterface

### sv/decimal_line_range_parser.sv
// ----------------------------------------------------------------------------
// Decimal line range parser
// One byte per cycle unless a held result stalls; the result word is registered.
// The parse step and range check sit between the line state and the result register.
// Reset clears the line state and the result slot and restores both limit registers.
// ----------------------------------------------------------------------------
module decimal_line_range_parser #(
    parameter int LINE_LIMIT = dlrp_pkg::LINE_LIMIT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dlrp_byte_if.sink                         rx,
    dlrp_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [dlrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dlrp_pkg::NUM_W-1:0]        cfg_wdata
);

    import dlrp_pkg::*;

    localparam int CNT_W   = $clog2(LINE_LIMIT);
    localparam int MAGX_W  = MAG_W + 4;
    localparam int VAL_W   = MAG_W + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LIMIT - 1);

    typedef enum logic [1:0] {
        PH_WS,
        PH_SIGN,
        PH_DIG,
        PH_BAD
    } phase_t;

    logic signed [NUM_W-1:0] min_reg, min_next;
    logic signed [NUM_W-1:0] max_reg, max_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    phase_t                  phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic                    res_valid_reg, res_valid_next;
    status_t                 res_status_reg, res_status_next;
    logic signed [NUM_W-1:0] res_number_reg, res_number_next;

    logic                    accept;
    logic                    is_nl;
    logic                    is_ws;
    logic                    is_digit;
    logic                    is_sign;
    logic [3:0]              digit;
    logic [MAGX_W-1:0]       mag_x;
    logic [MAGX_W-1:0]       prod;
    logic [MAG_W-1:0]        mag_step;
    logic                    line_ok;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] min_x;
    logic signed [VAL_W-1:0] max_x;
    status_t                 nl_status;

    assign rx.ready = !res_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    assign is_nl    = (rx.rx_byte == CHAR_NEWLINE);
    assign is_ws    = (rx.rx_byte == CHAR_SPACE) || (rx.rx_byte == CHAR_TAB)
                   || (rx.rx_byte == CHAR_VTAB) || (rx.rx_byte == CHAR_FEED)
                   || (rx.rx_byte == CHAR_RETURN);
    assign is_digit = (rx.rx_byte >= CHAR_ZERO) && (rx.rx_byte <= CHAR_NINE);
    assign is_sign  = (rx.rx_byte == CHAR_PLUS) || (rx.rx_byte == CHAR_MINUS);
    assign digit    = rx.rx_byte[3:0];

    assign mag_x    = {4'b0000, mag_reg};
    assign prod     = (mag_x << 3) + (mag_x << 1) + {{(MAGX_W-4){1'b0}}, digit};
    assign mag_step = (prod > {4'b0000, MAG_CAP}) ? MAG_CAP : prod[MAG_W-1:0];

    assign line_ok  = (cnt_reg == '0) || (phase_reg == PH_DIG);
    assign min_x    = {{(VAL_W-NUM_W){min_reg[NUM_W-1]}}, min_reg};
    assign max_x    = {{(VAL_W-NUM_W){max_reg[NUM_W-1]}}, max_reg};

    always_comb
    begin
        value = '0;
        if (line_ok && (cnt_reg != '0))
        begin
            if (neg_reg)
            begin
                value = -$signed({1'b0, mag_reg});
            end
            else if (mag_reg[MAG_W-1])
            begin
                value = $signed({2'b00, {(MAG_W-1){1'b1}}});
            end
            else
            begin
                value = $signed({1'b0, mag_reg});
            end
        end

        if (!line_ok)
        begin
            nl_status = ST_NOT_NUMBER;
        end
        else if (value < min_x)
        begin
            nl_status = ST_TOO_SMALL;
        end
        else if (value > max_x)
        begin
            nl_status = ST_TOO_LARGE;
        end
        else
        begin
            nl_status = ST_ACCEPTED;
        end
    end

    always_comb
    begin
        min_next        = min_reg;
        max_next        = max_reg;
        mag_next        = mag_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_status_next = res_status_reg;
        res_number_next = res_number_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_ALLOWED: min_next = cfg_wdata;
                CFG_MAX_ALLOWED: max_next = cfg_wdata;
                default:         ;
            endcase
        end

        if (accept)
        begin
            if (is_nl)
            begin
                res_valid_next  = 1'b1;
                res_status_next = nl_status;
                res_number_next = (nl_status == ST_ACCEPTED) ? value[NUM_W-1:0] : '0;
                mag_next        = '0;
                cnt_next        = '0;
                phase_next      = PH_WS;
                neg_next        = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WS:
                    begin
                        if (is_sign)
                        begin
                            neg_next   = (rx.rx_byte == CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            mag_next   = {{(MAG_W-4){1'b0}}, digit};
                            phase_next = PH_DIG;
                        end
                        else if (!is_ws)
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_SIGN, PH_DIG:
                    begin
                        if (is_digit)
                        begin
                            mag_next   = mag_step;
                            phase_next = PH_DIG;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    default: ;
                endcase

                if (cnt_reg == CNT_LAST)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_TOO_LONG;
                    res_number_next = '0;
                    mag_next        = '0;
                    cnt_next        = '0;
                    phase_next      = PH_WS;
                    neg_next        = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= MIN_ALLOWED_RESET;
            max_reg       <= MAX_ALLOWED_RESET;
            mag_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= PH_WS;
            neg_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            mag_reg       <= mag_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_number_reg <= res_number_next;
    end

    assign result.valid  = res_valid_reg;
    assign result.status = res_status_reg;
    assign result.number = res_number_reg;

endmodule

### sv/dlrp_checker.sv
// ----------------------------------------------------------------------------
// Decimal line range parser checker
// Port-level checks on the byte and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "decimal_line_range_parser_assert.svh"

module dlrp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rx_valid,
    input logic                              rx_ready,
    input logic [dlrp_pkg::BYTE_W-1:0]       rx_byte,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [dlrp_pkg::STATUS_W-1:0]     res_status,
    input logic signed [dlrp_pkg::NUM_W-1:0] res_number
);

    import dlrp_pkg::*;

    logic rx_take;
    logic res_take;

    assign rx_take  = rx_valid && rx_ready;
    assign res_take = res_valid && res_ready;

    `DLRP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_status, res_number}))
    `DLRP_ASSERT_SAME(a_number_zero, res_valid && (res_status != ST_ACCEPTED), res_number == '0)
    `DLRP_ASSERT_NEXT(a_newline_result, rx_take && (rx_byte == CHAR_NEWLINE), res_valid)
    `DLRP_ASSERT_NEXT(a_no_spurious, res_take && !rx_take, !res_valid)

endmodule

bind decimal_line_range_parser dlrp_checker u_dlrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .rx_byte    (rx.rx_byte),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_number (result.number)
);
